// File: src/smas_pkg.sv
// Shared constants, types and helpers of the square matrix add/sub/multiply block.
package smas_pkg;

	localparam int DIM          = 5;
	localparam int ELEM_WIDTH   = 16;
	localparam int RESULT_WIDTH = 34;
	localparam int IDX_W        = 3;
	localparam int CELLS        = DIM * DIM;
	localparam int ADDR_W       = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam logic [1:0] CMD_WR_A  = 2'd0;
	localparam logic [1:0] CMD_WR_B  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

	// One read slot travelling down the pipeline.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             first;
		logic             last;
		logic [1:0]       op;
	} tag_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		cell_addr = ADDR_W'(int'(r) * DIM + int'(c));
	endfunction

endpackage

// File: src/square_matrix_add_sub_multiply.sv
// Top level of the square matrix add/sub/multiply block.
//
// Usage:
//   Input stream (s_*): tuser carries the command, tdata the row, column and
//   value. Write-A and write-B items store one element each. A start
//   item launches a run that emits every element of A+B, A-B
//   or A*B, chosen by the operation register, in row-major order on the
//   output stream (m_*), with tlast on the final element. Writes with an
//   out-of-range row or column, unused commands and starts under an unused
//   operation are dropped without a result.
//   Rate: a run issues one RAM read pair per cycle while the output is not
//   stalled: DIM*DIM reads for add/sub, DIM*DIM*DIM for multiply, where
//   each multiply result sums DIM products.
//   s_tready is low while the sequencer issues reads; a new item is taken as
//   soon as the last read of a run is out, even with results in flight.
//   Stall: when a result is pending and m_tready is low, the whole
//   read/accumulate pipeline holds, and the pending result waits in the output register.
//   Reset: clears control state and the operation register (sum); matrix
//   contents stay undefined until written. cfg_we writes the operation.
module square_matrix_add_sub_multiply (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], result[39:6]
	output logic        m_tlast
);

	logic [1:0]                              op_q;
	logic [1:0]                              cmd;
	logic [smas_pkg::IDX_W-1:0]              in_row, in_col;
	logic [smas_pkg::ELEM_WIDTH-1:0]         in_value;
	logic                                    accept, in_range, start;
	logic                                    a_we, b_we;
	logic [smas_pkg::ADDR_W-1:0]             waddr, a_addr, b_addr;
	logic                                    busy, re, advance;
	logic [smas_pkg::ELEM_WIDTH-1:0]         a_data, b_data;
	smas_pkg::tag_t                          tag_s1;
	logic [smas_pkg::IDX_W-1:0]              out_row, out_col;
	logic [smas_pkg::RESULT_WIDTH-1:0]       out_result;

	// Unpack the input item.
	assign cmd      = s_tuser;
	assign in_row   = s_tdata[2:0];
	assign in_col   = s_tdata[5:3];
	assign in_value = s_tdata[21:6];

	// Take items only while no run is issuing reads.
	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;
	assign in_range = (int'(in_row) < smas_pkg::DIM) && (int'(in_col) < smas_pkg::DIM);
	assign waddr    = smas_pkg::cell_addr(in_row, in_col);
	assign a_we     = accept && in_range && (cmd == smas_pkg::CMD_WR_A);
	assign b_we     = accept && in_range && (cmd == smas_pkg::CMD_WR_B);
	// Drop a start under the unused operation code.
	assign start    = accept && (cmd == smas_pkg::CMD_START) &&
		(op_q == smas_pkg::OP_ADD || op_q == smas_pkg::OP_SUB || op_q == smas_pkg::OP_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= smas_pkg::OP_ADD;
		end else if (cfg_we) begin
			op_q <= cfg_wdata;
		end
	end

	smas_ram #(
		.DEPTH  (smas_pkg::CELLS),
		.WIDTH  (smas_pkg::ELEM_WIDTH),
		.ADDR_W (smas_pkg::ADDR_W)
	) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (in_value),
		.re    (re),
		.raddr (a_addr),
		.rdata (a_data)
	);

	smas_ram #(
		.DEPTH  (smas_pkg::CELLS),
		.WIDTH  (smas_pkg::ELEM_WIDTH),
		.ADDR_W (smas_pkg::ADDR_W)
	) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (in_value),
		.re    (re),
		.raddr (b_addr),
		.rdata (b_data)
	);

	smas_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (op_q),
		.advance (advance),
		.busy    (busy),
		.re      (re),
		.a_addr  (a_addr),
		.b_addr  (b_addr),
		.tag_s1  (tag_s1)
	);

	smas_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag_s1     (tag_s1),
		.a_data     (a_data),
		.b_data     (b_data),
		.advance    (advance),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_result (out_result),
		.out_last   (m_tlast)
	);

	// Pack the result item.
	assign m_tdata = {out_result, out_col, out_row};

`ifndef ASSERT_OFF
	// The final element of a run sits at the bottom-right corner.
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (out_row == smas_pkg::IDX_LAST &&
			out_col == smas_pkg::IDX_LAST))
		else $error("tlast away from the last element");

	// No element write while reads of a run are being issued.
	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(a_we || b_we))
		else $error("element write during a run");

	// An accepted start launches the sequencer.
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy)
		else $error("start did not launch a run");

	// Reads are issued only while the result path can move.
	a_read_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !re)
		else $error("read issued under output stall");
`endif

endmodule

// File: src/smas_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module smas_ram #(
	parameter int DEPTH  = 25,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/smas_seq.sv
// Read sequencer: walks rows, columns and the inner index and issues RAM reads.
module smas_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [1:0]                       op,
	input  logic                             advance,
	output logic                             busy,
	output logic                             re,
	output logic [smas_pkg::ADDR_W-1:0]      a_addr,
	output logic [smas_pkg::ADDR_W-1:0]      b_addr,
	output smas_pkg::tag_t                   tag_s1
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_state_t;

	seq_state_t                   state_q;
	logic [smas_pkg::IDX_W-1:0]   r_q, c_q, k_q;
	logic [1:0]                   op_q;
	logic                         mul;
	logic                         k_end, c_end, r_end;

	assign mul   = (op_q == smas_pkg::OP_MUL);
	assign k_end = !mul || (k_q == smas_pkg::IDX_LAST);
	assign c_end = (c_q == smas_pkg::IDX_LAST);
	assign r_end = (r_q == smas_pkg::IDX_LAST);

	assign busy = (state_q == ST_RUN);
	assign re   = advance;

	assign a_addr = mul ? smas_pkg::cell_addr(r_q, k_q) : smas_pkg::cell_addr(r_q, c_q);
	assign b_addr = mul ? smas_pkg::cell_addr(k_q, c_q) : smas_pkg::cell_addr(r_q, c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			op_q    <= smas_pkg::OP_ADD;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						op_q    <= op;
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (advance) begin
						if (!k_end) begin
							k_q <= k_q + 1'b1;
						end else begin
							k_q <= '0;
							if (!c_end) begin
								c_q <= c_q + 1'b1;
							end else begin
								c_q <= '0;
								if (r_end) begin
									state_q <= ST_IDLE;
								end else begin
									r_q <= r_q + 1'b1;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Tag follows the read data out of the RAM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (advance) begin
			tag_s1.valid <= busy;
			tag_s1.row   <= r_q;
			tag_s1.col   <= c_q;
			tag_s1.first <= (k_q == '0);
			tag_s1.last  <= k_end;
			tag_s1.op    <= op_q;
		end
	end

endmodule

// File: src/smas_dp.sv
// Datapath: forms one term per read, accumulates it and holds the result item.
module smas_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smas_pkg::tag_t                       tag_s1,
	input  logic [smas_pkg::ELEM_WIDTH-1:0]      a_data,
	input  logic [smas_pkg::ELEM_WIDTH-1:0]      b_data,
	output logic                                 advance,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [smas_pkg::IDX_W-1:0]           out_row,
	output logic [smas_pkg::IDX_W-1:0]           out_col,
	output logic [smas_pkg::RESULT_WIDTH-1:0]    out_result,
	output logic                                 out_last
);

	logic signed [smas_pkg::ELEM_WIDTH-1:0]     a_s, b_s;
	logic signed [2*smas_pkg::ELEM_WIDTH-1:0]   prod;
	logic signed [smas_pkg::RESULT_WIDTH-1:0]   term;
	logic signed [smas_pkg::RESULT_WIDTH-1:0]   term_s2;
	smas_pkg::tag_t                             tag_s2;
	logic [smas_pkg::RESULT_WIDTH-1:0]          acc_q;
	logic [smas_pkg::RESULT_WIDTH-1:0]          acc_next;

	// Whole pipeline moves while the output register is free or being emptied.
	assign advance = !out_valid || out_ready;

	assign a_s  = a_data;
	assign b_s  = b_data;
	assign prod = a_s * b_s;

	always_comb begin
		case (tag_s1.op)
			smas_pkg::OP_ADD: term = smas_pkg::RESULT_WIDTH'(a_s) + smas_pkg::RESULT_WIDTH'(b_s);
			smas_pkg::OP_SUB: term = smas_pkg::RESULT_WIDTH'(a_s) - smas_pkg::RESULT_WIDTH'(b_s);
			smas_pkg::OP_MUL: term = smas_pkg::RESULT_WIDTH'(prod);
			default:          term = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (advance) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			term_s2 <= term;
		end
	end

	assign acc_next = tag_s2.first ? term_s2 : acc_q + term_s2;

	always_ff @(posedge clk) begin
		if (advance && tag_s2.valid) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= tag_s2.valid && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tag_s2.valid && tag_s2.last) begin
			out_row    <= tag_s2.row;
			out_col    <= tag_s2.col;
			out_result <= acc_next;
			out_last   <= (tag_s2.row == smas_pkg::IDX_LAST) &&
				(tag_s2.col == smas_pkg::IDX_LAST);
		end
	end

endmodule
